// ===== hw/rtl/cmadc_pkg.sv =====
// Shared types and constants of the cell minimum-area donor check block.
`timescale 1ns / 1ps
`default_nettype none

package cmadc_pkg;

   // Fixed field widths of the item ports
   localparam int CELL_BITS      = 12;
   localparam int FACE_AREA_BITS = 32;
   localparam int FRAC_BITS      = 17;
   localparam int QUO_BITS       = 16;
   localparam int STEP_BITS      = 4;

   localparam logic [FRAC_BITS-1:0] ONE_Q16      = 17'd65536;
   localparam logic [FRAC_BITS-1:0] THRESH_RESET = 17'd32768;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = 1;
   localparam int COUNT_BITS  = 2;

   // Action codes on the request channel
   localparam logic [1:0] ACT_FACE  = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_PAIR  = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   // Classified operation handed to the back end
   typedef enum logic [1:0] {
      OP_FACE,
      OP_QUERY,
      OP_PAIR,
      OP_NOPAIR
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [CELL_BITS-1:0]      cell_a;
      logic                      a_ok;
      logic [CELL_BITS-1:0]      cell_b;
      logic                      b_ok;
      logic [FACE_AREA_BITS-1:0] area;
   } cmd_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_out_type;

   // Back end status returned to the front
   typedef struct packed {
      logic pop;
      logic clearing;
   } bk_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cmadc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cmadc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cmadc_front.sv =====
// Front end: accepts request items, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module cmadc_front #(
   parameter int CELLS = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_action,
   input  wire logic [cmadc_pkg::CELL_BITS-1:0]  req_owner_cell,
   input  wire logic [cmadc_pkg::CELL_BITS-1:0]  req_neighbour_cell,
   input  wire logic [cmadc_pkg::FACE_AREA_BITS-1:0] req_face_area,
   input  wire logic [cmadc_pkg::CELL_BITS-1:0]  req_query_cell,
   input  wire logic [cmadc_pkg::CELL_BITS-1:0]  req_acceptor_cell,
   input  wire logic [cmadc_pkg::CELL_BITS-1:0]  req_donor_cell,
   input  wire logic                             req_donor_found,
   output cmadc_pkg::q_out_type                  q_out,
   input  wire cmadc_pkg::bk_stat_type           stat
);

   import cmadc_pkg::*;

   cmd_type               q_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  push;
   cmd_type               cmd;

   function automatic logic cell_ok(input logic [CELL_BITS-1:0] idx);
      cell_ok = (32'(idx) < 32'(CELLS));
   endfunction

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] ptr);
      ptr_next = (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_BITS'(1);
   endfunction

   // Accept while the queue has room and the table is not being cleared
   assign req_ready = (count_ff != COUNT_BITS'(QUEUE_DEPTH)) && !stat.clearing;
   assign push      = req_valid && req_ready && (req_action != ACT_NONE);

   // Classify the item into one command
   always_comb begin
      cmd        = '0;
      cmd.area   = req_face_area;
      case (req_action)
         ACT_FACE: begin
            cmd.op     = OP_FACE;
            cmd.cell_a = req_owner_cell;
            cmd.a_ok   = cell_ok(req_owner_cell);
            cmd.cell_b = req_neighbour_cell;
            // same cell twice is lowered only once
            cmd.b_ok   = cell_ok(req_neighbour_cell) &&
                         (req_neighbour_cell != req_owner_cell);
         end
         ACT_QUERY: begin
            cmd.op     = OP_QUERY;
            cmd.cell_a = req_query_cell;
            cmd.a_ok   = cell_ok(req_query_cell);
         end
         default: begin
            cmd.op     = req_donor_found ? OP_PAIR : OP_NOPAIR;
            cmd.cell_a = req_acceptor_cell;
            cmd.a_ok   = cell_ok(req_acceptor_cell);
            cmd.cell_b = req_donor_cell;
            cmd.b_ok   = cell_ok(req_donor_cell);
         end
      endcase
   end

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = stat.pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + COUNT_BITS'(push) - COUNT_BITS'(stat.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.cmd   = q_ff[rd_ptr_ff];

   // Queue never overfills and never pops when empty
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("command queue overfilled");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      stat.pop |-> (count_ff != '0))
      else $error("pop from empty command queue");

endmodule

`default_nettype wire

// ===== hw/rtl/cmadc_back.sv =====
// Back end: clears and updates the area table, evaluates pairs, holds the response.
`timescale 1ns / 1ps
`default_nettype none

module cmadc_back #(
   parameter int CELLS     = 4096,
   parameter int AREA_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire cmadc_pkg::q_out_type                 q_in,
   output cmadc_pkg::bk_stat_type                    stat,
   input  wire logic [cmadc_pkg::FRAC_BITS-1:0]      threshold,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [cmadc_pkg::FACE_AREA_BITS-1:0]      rsp_cell_min_area,
   output logic [cmadc_pkg::FRAC_BITS-1:0]           rsp_fraction,
   output logic                                      rsp_suitable
);

   import cmadc_pkg::*;

   localparam int IDX_BITS = $clog2(CELLS);
   localparam int REM_BITS = AREA_BITS + 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RDA,
      S_RDB,
      S_DIV,
      S_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [AREA_BITS-1:0]      a_ent_ff, a_ent_in;
   logic [REM_BITS-1:0]       rem_ff, rem_in;
   logic [REM_BITS-1:0]       div_ff, div_in;
   logic [QUO_BITS-1:0]       quo_ff, quo_in;
   logic [STEP_BITS-1:0]      step_ff, step_in;
   logic [IDX_BITS-1:0]       clr_ff, clr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [FACE_AREA_BITS-1:0] rsp_area_ff, rsp_area_in;
   logic [FRAC_BITS-1:0]      rsp_frac_ff, rsp_frac_in;
   logic                      rsp_suit_ff, rsp_suit_in;

   logic                      wr_en;
   logic [IDX_BITS-1:0]       wr_addr;
   logic [AREA_BITS-1:0]      wr_data;
   logic [IDX_BITS-1:0]       rd_addr;
   logic [AREA_BITS-1:0]      rd_data;
   logic [AREA_BITS-1:0]      ent;
   logic [AREA_BITS-1:0]      area_cut;
   logic [AREA_BITS-1:0]      hi;
   logic [AREA_BITS-1:0]      diff;
   logic [REM_BITS:0]         trial;
   logic [REM_BITS:0]         trial_sub;
   logic                      trial_ge;
   logic [FRAC_BITS-1:0]      frac;

   cmadc_ram #(
      .WIDTH (AREA_BITS),
      .DEPTH (CELLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Table read address: cell A when popping, cell B afterwards
   assign rd_addr = (state_ff == S_IDLE) ? IDX_BITS'(q_in.cmd.cell_a)
                                         : IDX_BITS'(cmd_ff.cell_b);

   // Entry seen this cycle; a cell beyond the table reads as all ones
   assign ent = ((state_ff == S_RDA) ? cmd_ff.a_ok : cmd_ff.b_ok) ? rd_data : '1;
   assign area_cut = AREA_BITS'(cmd_ff.area);

   // Pair operands
   assign hi   = (a_ent_ff > ent) ? a_ent_ff : ent;
   assign diff = (a_ent_ff > ent) ? (a_ent_ff - ent) : (ent - a_ent_ff);

   // One restoring divide step per cycle
   assign trial     = {rem_ff, 1'b0};
   assign trial_ge  = (trial >= {1'b0, div_ff});
   assign trial_sub = trial - {1'b0, div_ff};

   assign frac = ONE_Q16 - FRAC_BITS'(quo_ff);

   assign stat.clearing = (state_ff == S_CLEAR);
   assign stat.pop      = (state_ff == S_IDLE) && q_in.valid;

   // Sequencer next state, table writes and response loading
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      a_ent_in     = a_ent_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_area_in  = rsp_area_ff;
      rsp_frac_in  = rsp_frac_ff;
      rsp_suit_in  = rsp_suit_ff;
      wr_en        = 1'b0;
      wr_addr      = IDX_BITS'(cmd_ff.cell_a);
      wr_data      = area_cut;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '1;
            clr_in  = clr_ff + IDX_BITS'(1);
            if (clr_ff == IDX_BITS'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_in.valid) begin
               cmd_in   = q_in.cmd;
               state_in = (q_in.cmd.op == OP_NOPAIR) ? S_EMIT : S_RDA;
            end
         end
         S_RDA: begin
            a_ent_in = ent;
            case (cmd_ff.op)
               OP_FACE: begin
                  wr_en    = cmd_ff.a_ok && (area_cut < ent);
                  wr_addr  = IDX_BITS'(cmd_ff.cell_a);
                  state_in = S_RDB;
               end
               OP_QUERY: begin
                  state_in = S_EMIT;
               end
               OP_PAIR: begin
                  state_in = S_RDB;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RDB: begin
            if (cmd_ff.op == OP_FACE) begin
               wr_en    = cmd_ff.b_ok && (area_cut < ent);
               wr_addr  = IDX_BITS'(cmd_ff.cell_b);
               state_in = S_IDLE;
            end else begin
               rem_in   = REM_BITS'(diff);
               div_in   = REM_BITS'(hi) + REM_BITS'(1);
               quo_in   = '0;
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = trial_ge ? trial_sub[REM_BITS-1:0] : trial[REM_BITS-1:0];
            quo_in  = {quo_ff[QUO_BITS-2:0], trial_ge};
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(QUO_BITS - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_area_in  = '0;
               rsp_frac_in  = '0;
               rsp_suit_in  = 1'b0;
               case (cmd_ff.op)
                  OP_QUERY: begin
                     rsp_area_in = FACE_AREA_BITS'(a_ent_ff);
                  end
                  OP_PAIR: begin
                     rsp_frac_in = frac;
                     rsp_suit_in = (frac > threshold);
                  end
                  default: begin
                     rsp_frac_in = '0;
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      a_ent_ff    <= a_ent_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      rsp_area_ff <= rsp_area_in;
      rsp_frac_ff <= rsp_frac_in;
      rsp_suit_ff <= rsp_suit_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_min_area = rsp_area_ff;
   assign rsp_fraction      = rsp_frac_ff;
   assign rsp_suitable      = rsp_suit_ff;

   // The divider never touches the table
   a_no_write_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> !wr_en)
      else $error("table write during divide");

   // Partial remainder stays below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder out of range");

   // No command leaves the queue before the clearing pass is over
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !stat.pop)
      else $error("command taken during clearing pass");

endmodule

`default_nettype wire

// ===== hw/rtl/cell_min_area_donor_check.sv =====
// Top level of the cell minimum-area table with donor suitability check.
`timescale 1ns / 1ps
`default_nettype none

// Keeps the smallest face area seen per cell and rates donor/acceptor pairs.
// After reset the table is filled with all ones by a clearing pass over all
// CELLS entries, during which req_ready stays low (threshold writes are still
// taken). Items then go into a two-entry command queue and are run one at a
// time by the back end, which has a single table port: a face update does two
// read-modify-writes, a query reads its cell and then loads the response
// register, a pair without donor loads the response directly, and a pair with
// donor reads both cells and runs the radix-2 restoring divider that forms the
// Q0.16 quotient |a-d|*65536/(max(a,d)+1). A finished response sits in an
// output register while the front keeps accepting items until the queue is full.

module cell_min_area_donor_check #(
   parameter int CELLS     = 4096,
   parameter int AREA_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [1:0]                            req_action,
   input  wire logic [cmadc_pkg::CELL_BITS-1:0]       req_owner_cell,
   input  wire logic [cmadc_pkg::CELL_BITS-1:0]       req_neighbour_cell,
   input  wire logic [cmadc_pkg::FACE_AREA_BITS-1:0]  req_face_area,
   input  wire logic [cmadc_pkg::CELL_BITS-1:0]       req_query_cell,
   input  wire logic [cmadc_pkg::CELL_BITS-1:0]       req_acceptor_cell,
   input  wire logic [cmadc_pkg::CELL_BITS-1:0]       req_donor_cell,
   input  wire logic                                  req_donor_found,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [cmadc_pkg::FACE_AREA_BITS-1:0]       rsp_cell_min_area,
   output logic [cmadc_pkg::FRAC_BITS-1:0]            rsp_fraction,
   output logic                                       rsp_suitable,
   input  wire logic                                  csr_wr_en,
   input  wire logic [cmadc_pkg::FRAC_BITS-1:0]       csr_wr_data
);

   import cmadc_pkg::*;

   logic [FRAC_BITS-1:0] threshold_ff, threshold_in;
   q_out_type            q_out;
   bk_stat_type          stat;

   // Threshold register
   assign threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   cmadc_front #(
      .CELLS (CELLS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_owner_cell     (req_owner_cell),
      .req_neighbour_cell (req_neighbour_cell),
      .req_face_area      (req_face_area),
      .req_query_cell     (req_query_cell),
      .req_acceptor_cell  (req_acceptor_cell),
      .req_donor_cell     (req_donor_cell),
      .req_donor_found    (req_donor_found),
      .q_out              (q_out),
      .stat               (stat)
   );

   cmadc_back #(
      .CELLS     (CELLS),
      .AREA_BITS (AREA_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_in              (q_out),
      .stat              (stat),
      .threshold         (threshold_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_min_area (rsp_cell_min_area),
      .rsp_fraction      (rsp_fraction),
      .rsp_suitable      (rsp_suitable)
   );

endmodule

`default_nettype wire
